>>> hdl/cmae_pkg.sv
// shared constants, types and state codes for the centered moving average block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cmae_pkg;

  localparam int MAX_RADIUS  = 15;
  localparam int SAMPLE_BITS = 32;
  localparam int CHANNELS    = 3;
  localparam int HW_W        = 4;
  localparam int RING_DEPTH  = 2 * MAX_RADIUS + 2;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int RING_W      = CHANNELS * SAMPLE_BITS;
  localparam int RAD_W       = $clog2(MAX_RADIUS + 1);
  localparam int OFFS_W      = $clog2(MAX_RADIUS + 2);
  localparam int SEEN_W      = $clog2(RING_DEPTH + 1);
  localparam int WIN_W       = $clog2(2 * MAX_RADIUS + 2);
  localparam int SUM_W       = SAMPLE_BITS + $clog2(2 * MAX_RADIUS + 1);
  localparam int NUM_W       = SUM_W + 1;
  localparam int DEN_W       = $clog2(2 * (2 * MAX_RADIUS + 1) + 1);
  localparam int CNT_W       = $clog2(NUM_W + 1);
  localparam int JQ_DEPTH    = 4;
  localparam int JQ_AW       = $clog2(JQ_DEPTH);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [RING_AW-1:0] center;
    logic [RAD_W-1:0]   radius;
    logic               fin;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SUM,
    BK_DIV,
    BK_OUT
  } back_state_e;

endpackage

`default_nettype wire

>>> hdl/centered_moving_average_edge_shrink_top.sv
// top level of the centered moving average with edge shrink
// depends on cmae_pkg, cmae_ram, cmae_front, cmae_jobq, cmae_back
`timescale 1ns / 1ps
`default_nettype none

// Three-channel centered moving average. Each sample beat is pushed while full
// is low; results come out in order, each the rounded mean over a window of
// radius min(i, n-1-i, half_window), once the window is complete or when the
// beat marked end_of_series arrives. Samples live in a 32-entry ring ram with
// one read port. A result sums its window through that port, forms the
// numerator, runs a one-bit-per-cycle divider and is handed to the output
// register; a new sample is taken only after all results of the previous
// one are computed. The last beat of a series may release up to 16 results.
// half_window may be written only while the block is idle.
module centered_moving_average_edge_shrink_top
  import cmae_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire sample_t         confirmed_count_i,
  input  wire sample_t         recovered_count_i,
  input  wire sample_t         death_count_i,
  input  wire logic            end_of_series_i,
  output logic                 empty,
  input  wire logic            pop,
  output sample_t              smooth_confirmed_o,
  output sample_t              smooth_recovered_o,
  output sample_t              smooth_deaths_o,
  output logic                 final_result_o,
  input  wire logic            half_window_we_i,
  input  wire logic [HW_W-1:0] half_window_i
);

  logic               ram_we;
  logic [RING_AW-1:0] ram_waddr, ram_raddr;
  logic [RING_W-1:0]  ram_wdata, ram_rdata;
  logic               jq_push, jq_full, jq_pop, jq_empty;
  job_t               jq_in, jq_out;
  logic               back_busy;
  logic               down_idle;

  assign down_idle = jq_empty & ~back_busy;

  cmae_ram #(
    .WIDTH(RING_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cmae_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .confirmed_i(confirmed_count_i),
    .recovered_i(recovered_count_i),
    .deaths_i   (death_count_i),
    .last_i     (end_of_series_i),
    .hw_we_i    (half_window_we_i),
    .hw_i       (half_window_i),
    .down_idle_i(down_idle),
    .job_full_i (jq_full),
    .job_push_o (jq_push),
    .job_o      (jq_in),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata)
  );

  cmae_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (jq_push),
    .job_i  (jq_in),
    .full_o (jq_full),
    .pop_i  (jq_pop),
    .job_o  (jq_out),
    .empty_o(jq_empty)
  );

  cmae_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_i             (jq_out),
    .job_empty_i       (jq_empty),
    .job_pop_o         (jq_pop),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata),
    .busy_o            (back_busy),
    .empty             (empty),
    .pop               (pop),
    .smooth_confirmed_o(smooth_confirmed_o),
    .smooth_recovered_o(smooth_recovered_o),
    .smooth_deaths_o   (smooth_deaths_o),
    .final_result_o    (final_result_o)
  );

  // a ring write never lands while a window read is pending
  a_ring_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (jq_empty && !back_busy))
    else $error("ring written while back end busy");

  a_jq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jq_full |-> !jq_push)
    else $error("job queue overflow");

  a_jq_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jq_empty |-> !jq_pop)
    else $error("job queue underflow");

endmodule

`default_nettype wire

>>> hdl/cmae_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cmae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/cmae_front.sv
// front end: takes samples, writes the ring, tracks series position and
// hands averaging jobs to the job queue; uses cmae_pkg
`timescale 1ns / 1ps
`default_nettype none

module cmae_front
  import cmae_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire sample_t             confirmed_i,
  input  wire sample_t             recovered_i,
  input  wire sample_t             deaths_i,
  input  wire logic                last_i,
  input  wire logic                hw_we_i,
  input  wire logic [HW_W-1:0]     hw_i,
  input  wire logic                down_idle_i,
  input  wire logic                job_full_i,
  output logic                     job_push_o,
  output job_t                     job_o,
  output logic                     ram_we_o,
  output logic [RING_AW-1:0]       ram_waddr_o,
  output logic [RING_W-1:0]        ram_wdata_o
);

  logic [HW_W-1:0]    hw_q;
  logic [RAD_W-1:0]   r_q, r_d;
  logic [SEEN_W-1:0]  seen_q, seen_d;
  logic [OFFS_W-1:0]  offs_q, offs_d;
  logic [RING_AW-1:0] wslot_q, wslot_d;
  logic               last_q, last_d;
  logic               gen_q, gen_d;
  logic               accept, need;
  logic [RING_AW:0]   ctr_tmp;
  logic [SEEN_W-1:0]  idx, ra, rb;

  assign full        = gen_q | ~down_idle_i;
  assign accept      = push & ~full;
  assign ram_we_o    = accept;
  assign ram_waddr_o = wslot_q;
  assign ram_wdata_o = {deaths_i, recovered_i, confirmed_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HW_W'(3);
    end else if (hw_we_i) begin
      hw_q <= hw_i;
    end
  end

  assign need = last_q ? (offs_q != '0) : (SEEN_W'(offs_q) > SEEN_W'(r_q));

  always_comb begin
    ctr_tmp = {1'b0, wslot_q} + (RING_AW + 1)'(RING_DEPTH) - (RING_AW + 1)'(offs_q);
    if (ctr_tmp >= (RING_AW + 1)'(RING_DEPTH)) begin
      ctr_tmp = ctr_tmp - (RING_AW + 1)'(RING_DEPTH);
    end
    idx = seen_q - SEEN_W'(offs_q);
    ra  = (idx < SEEN_W'(r_q)) ? idx : SEEN_W'(r_q);
    rb  = SEEN_W'(offs_q) - SEEN_W'(1);
    if (last_q && rb < ra) begin
      ra = rb;
    end
    job_o.center = ctr_tmp[RING_AW-1:0];
    job_o.radius = ra[RAD_W-1:0];
    job_o.fin    = last_q & (offs_q == OFFS_W'(1));
  end

  assign job_push_o = gen_q & need & ~job_full_i;

  always_comb begin
    r_d     = r_q;
    seen_d  = seen_q;
    offs_d  = offs_q;
    wslot_d = wslot_q;
    last_d  = last_q;
    gen_d   = gen_q;
    if (accept) begin
      r_d     = (int'(hw_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(hw_q);
      wslot_d = (wslot_q == RING_AW'(RING_DEPTH - 1)) ? '0 : wslot_q + RING_AW'(1);
      if (seen_q < SEEN_W'(RING_DEPTH)) begin
        seen_d = seen_q + SEEN_W'(1);
      end
      if (offs_q < OFFS_W'(MAX_RADIUS + 1)) begin
        offs_d = offs_q + OFFS_W'(1);
      end
      last_d = last_i;
      gen_d  = 1'b1;
    end else if (gen_q) begin
      if (!need) begin
        gen_d = 1'b0;
        if (last_q) begin
          seen_d = '0;
          offs_d = '0;
        end
      end else if (!job_full_i) begin
        offs_d = offs_q - OFFS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q     <= '0;
      seen_q  <= '0;
      offs_q  <= '0;
      wslot_q <= '0;
      last_q  <= 1'b0;
      gen_q   <= 1'b0;
    end else begin
      r_q     <= r_d;
      seen_q  <= seen_d;
      offs_q  <= offs_d;
      wslot_q <= wslot_d;
      last_q  <= last_d;
      gen_q   <= gen_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cmae_jobq.sv
// short job queue between the front end and the averaging back end
// uses cmae_pkg
`timescale 1ns / 1ps
`default_nettype none

module cmae_jobq
  import cmae_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      job_o,
  output logic      empty_o
);

  job_t             ent_q [JQ_DEPTH];
  logic [JQ_AW-1:0] wp_q, rp_q;
  logic [JQ_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (JQ_AW + 1)'(JQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + JQ_AW'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + JQ_AW'(1);
      end
      cnt_q <= cnt_q + (JQ_AW + 1)'(push_i) - (JQ_AW + 1)'(pop_i);
    end
  end

endmodule

`default_nettype wire

>>> hdl/cmae_back.sv
// back end: sums a window from the ring, divides with rounding one quotient
// bit per cycle and holds the result beat; uses cmae_pkg
`timescale 1ns / 1ps
`default_nettype none

module cmae_back
  import cmae_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire job_t               job_i,
  input  wire logic               job_empty_i,
  output logic                    job_pop_o,
  output logic [RING_AW-1:0]      ram_raddr_o,
  input  wire logic [RING_W-1:0]  ram_rdata_i,
  output logic                    busy_o,
  output logic                    empty,
  input  wire logic               pop,
  output sample_t                 smooth_confirmed_o,
  output sample_t                 smooth_recovered_o,
  output sample_t                 smooth_deaths_o,
  output logic                    final_result_o
);

  back_state_e          st_q, st_d;
  logic [RING_AW-1:0]   addr_q, addr_d;
  logic [WIN_W-1:0]     left_q, left_d;
  logic                 rdv_q, rdv_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic                 fin_q, fin_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [SUM_W-1:0]     acc_q [CHANNELS];
  logic [SUM_W-1:0]     acc_d [CHANNELS];
  logic [NUM_W-1:0]     num_q [CHANNELS];
  logic [NUM_W-1:0]     num_d [CHANNELS];
  logic [DEN_W-1:0]     rem_q [CHANNELS];
  logic [DEN_W-1:0]     rem_d [CHANNELS];
  logic [DEN_W:0]       trial [CHANNELS];
  logic                 outv_q, outv_d;
  sample_t              res_q [CHANNELS];
  logic                 resf_q;
  logic                 out_load;
  logic [RING_AW:0]     start_tmp;

  assign busy_o             = (st_q != BK_IDLE);
  assign empty              = ~outv_q;
  assign smooth_confirmed_o = res_q[0];
  assign smooth_recovered_o = res_q[1];
  assign smooth_deaths_o    = res_q[2];
  assign final_result_o     = resf_q;
  assign ram_raddr_o        = addr_q;

  always_comb begin
    start_tmp = {1'b0, job_i.center} + (RING_AW + 1)'(RING_DEPTH)
                - (RING_AW + 1)'(job_i.radius);
    if (start_tmp >= (RING_AW + 1)'(RING_DEPTH)) begin
      start_tmp = start_tmp - (RING_AW + 1)'(RING_DEPTH);
    end
  end

  always_comb begin
    st_d      = st_q;
    addr_d    = addr_q;
    left_d    = left_q;
    rdv_d     = 1'b0;
    den_d     = den_q;
    fin_d     = fin_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    num_d     = num_q;
    rem_d     = rem_q;
    job_pop_o = 1'b0;
    out_load  = 1'b0;
    outv_d    = outv_q & ~pop;
    for (int c = 0; c < CHANNELS; c++) begin
      trial[c] = {rem_q[c], num_q[c][NUM_W-1]};
    end
    unique case (st_q)
      BK_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          addr_d    = start_tmp[RING_AW-1:0];
          left_d    = {job_i.radius, 1'b1};
          den_d     = {job_i.radius, 2'b10};
          fin_d     = job_i.fin;
          for (int c = 0; c < CHANNELS; c++) begin
            acc_d[c] = '0;
          end
          st_d = BK_SUM;
        end
      end
      BK_SUM: begin
        if (rdv_q) begin
          for (int c = 0; c < CHANNELS; c++) begin
            acc_d[c] = acc_q[c] + SUM_W'(ram_rdata_i[c*SAMPLE_BITS +: SAMPLE_BITS]);
          end
        end
        if (left_q != '0) begin
          rdv_d  = 1'b1;
          left_d = left_q - WIN_W'(1);
          addr_d = (addr_q == RING_AW'(RING_DEPTH - 1)) ? '0 : addr_q + RING_AW'(1);
        end else if (!rdv_q) begin
          // numerator 2*sum + d, divisor 2*d
          for (int c = 0; c < CHANNELS; c++) begin
            num_d[c] = {acc_q[c], 1'b0} + NUM_W'(den_q[DEN_W-1:1]);
            rem_d[c] = '0;
          end
          cnt_d = CNT_W'(NUM_W);
          st_d  = BK_DIV;
        end
      end
      BK_DIV: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (trial[c] >= {1'b0, den_q}) begin
            rem_d[c] = DEN_W'(trial[c] - {1'b0, den_q});
            num_d[c] = {num_q[c][NUM_W-2:0], 1'b1};
          end else begin
            rem_d[c] = trial[c][DEN_W-1:0];
            num_d[c] = {num_q[c][NUM_W-2:0], 1'b0};
          end
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          st_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!outv_q || pop) begin
          out_load = 1'b1;
          outv_d   = 1'b1;
          st_d     = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= BK_IDLE;
      rdv_q  <= 1'b0;
      outv_q <= 1'b0;
      left_q <= '0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      rdv_q  <= rdv_d;
      outv_q <= outv_d;
      left_q <= left_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    den_q  <= den_d;
    fin_q  <= fin_d;
    acc_q  <= acc_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    if (out_load) begin
      for (int c = 0; c < CHANNELS; c++) begin
        res_q[c] <= num_q[c][SAMPLE_BITS-1:0];
      end
      resf_q <= fin_q;
    end
  end

endmodule

`default_nettype wire
